// ----- sv/mi3_pkg.sv -----
package mi3_pkg;

  localparam int NumEl    = 9;
  localparam int DivSteps = 32;

  typedef logic [3:0] idx_t;

  // Cofactor k (row-major) is a[CofA[k]] * a[CofB[k]] - a[CofC[k]] * a[CofD[k]].
  localparam idx_t CofA [NumEl] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam idx_t CofB [NumEl] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam idx_t CofC [NumEl] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam idx_t CofD [NumEl] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

  // Inverse element (r,c) takes cofactor (c,r).
  localparam idx_t AdjIdx [NumEl] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

  localparam logic [31:0] SatPos = 32'h7fff_ffff;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  typedef struct packed {
    logic [47:0] r;
    logic [31:0] n;
    logic [31:0] q;
    logic        neg;
    logic        ovf;
  } div_t;

  typedef struct packed {
    logic [8:0][15:0] a;
    logic [48:0]      det;
    logic [47:0]      dmag;
    logic             sing;
  } ctx_t;

endpackage

// ----- sv/matrix3x3_inverse.sv -----
// A word passes input, product, cofactor, determinant, divider and output registers.
// One matrix per cycle unless stalled; 32 divider stages resolve one quotient bit each.
// A stalled output register freezes the whole pipeline, so nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears only the valid bits of every stage.
module matrix3x3_inverse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] a00_i,
  input  logic signed [15:0] a01_i,
  input  logic signed [15:0] a02_i,
  input  logic signed [15:0] a10_i,
  input  logic signed [15:0] a11_i,
  input  logic signed [15:0] a12_i,
  input  logic signed [15:0] a20_i,
  input  logic signed [15:0] a21_i,
  input  logic signed [15:0] a22_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] b00_o,
  output logic signed [31:0] b01_o,
  output logic signed [31:0] b02_o,
  output logic signed [31:0] b10_o,
  output logic signed [31:0] b11_o,
  output logic signed [31:0] b12_o,
  output logic signed [31:0] b20_o,
  output logic signed [31:0] b21_o,
  output logic signed [31:0] b22_o,
  output logic               singular_o,
  output logic signed [48:0] determinant_o
);

  localparam int N = mi3_pkg::NumEl;
  localparam int L = mi3_pkg::DivSteps;

  logic en;
  logic signed [15:0] a_in [N];

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [15:0] a1_q [N];
  logic signed [15:0] a2_q [N];
  logic signed [15:0] a3_q [N];
  logic signed [15:0] a4_q [N];
  logic signed [15:0] a5_q [N];
  logic signed [31:0] pa_d [N];
  logic signed [31:0] pb_d [N];
  logic signed [31:0] pa_q [N];
  logic signed [31:0] pb_q [N];
  logic signed [31:0] cof3_q [N];
  logic signed [31:0] cof4_q [N];
  logic signed [31:0] cof5_q [N];
  logic signed [47:0] dp_d [3];
  logic signed [47:0] dp_q [3];
  logic [48:0] det_d;
  logic [48:0] det5_q;

  mi3_pkg::div_t div_d [N];
  mi3_pkg::ctx_t ctx_d;
  mi3_pkg::div_t div_q [L+1][N];
  mi3_pkg::ctx_t ctx_q [L+1];
  logic [L:0]    vld_q;

  logic [31:0] b_d [N];
  logic [31:0] b_q [N];
  logic        out_valid_q;
  logic        sing_q;
  logic [48:0] det_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign a_in[0] = a00_i;
  assign a_in[1] = a01_i;
  assign a_in[2] = a02_i;
  assign a_in[3] = a10_i;
  assign a_in[4] = a11_i;
  assign a_in[5] = a12_i;
  assign a_in[6] = a20_i;
  assign a_in[7] = a21_i;
  assign a_in[8] = a22_i;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      pa_d[k] = a1_q[mi3_pkg::CofA[k]] * a1_q[mi3_pkg::CofB[k]];
      pb_d[k] = a1_q[mi3_pkg::CofC[k]] * a1_q[mi3_pkg::CofD[k]];
    end
    for (int j = 0; j < 3; j++) begin
      dp_d[j] = a3_q[j] * cof3_q[j];
    end
    det_d = {dp_q[0][47], dp_q[0]} + {dp_q[1][47], dp_q[1]} + {dp_q[2][47], dp_q[2]};
  end

  always_comb begin
    logic [31:0] cv;
    logic [31:0] nm;
    ctx_d.det  = det5_q;
    ctx_d.dmag = det5_q[48] ? 48'(-det5_q) : det5_q[47:0];
    ctx_d.sing = (det5_q == '0);
    for (int k = 0; k < N; k++) begin
      ctx_d.a[k] = a5_q[k];
    end
    for (int e = 0; e < N; e++) begin
      cv = cof5_q[mi3_pkg::AdjIdx[e]];
      nm = cv[31] ? -cv : cv;
      div_d[e].neg = cv[31] ^ det5_q[48];
      div_d[e].ovf = {20'b0, nm} >= {ctx_d.dmag, 4'b0};
      div_d[e].r   = {20'b0, nm[31:4]};
      div_d[e].n   = {nm[3:0], 28'b0};
      div_d[e].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vld_q <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vld_q <= {vld_q[L-1:0], v5_q};
      out_valid_q <= vld_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q   <= a_in;
      a2_q   <= a1_q;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      a3_q   <= a2_q;
      for (int k = 0; k < N; k++) begin
        cof3_q[k] <= pa_q[k] - pb_q[k];
      end
      a4_q   <= a3_q;
      cof4_q <= cof3_q;
      dp_q   <= dp_d;
      a5_q   <= a4_q;
      cof5_q <= cof4_q;
      det5_q <= det_d;
      div_q[0] <= div_d;
      ctx_q[0] <= ctx_d;
      b_q    <= b_d;
      sing_q <= ctx_q[L].sing;
      det_q  <= ctx_q[L].det;
    end
  end

  for (genvar s = 0; s < L; s++) begin : g_div
    mi3_pkg::div_t step_d [N];

    always_comb begin
      logic [48:0] rs;
      logic [48:0] dd;
      logic        ge;
      dd = {1'b0, ctx_q[s].dmag};
      for (int e = 0; e < N; e++) begin
        rs = {div_q[s][e].r, div_q[s][e].n[31]};
        ge = rs >= dd;
        step_d[e]     = div_q[s][e];
        step_d[e].r   = ge ? 48'(rs - dd) : rs[47:0];
        step_d[e].n   = {div_q[s][e].n[30:0], 1'b0};
        step_d[e].q   = {div_q[s][e].q[30:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[s+1] <= step_d;
        ctx_q[s+1] <= ctx_q[s];
      end
    end
  end

  always_comb begin
    mi3_pkg::div_t d;
    for (int e = 0; e < N; e++) begin
      d = div_q[L][e];
      if (ctx_q[L].sing) begin
        b_d[e] = {{12{ctx_q[L].a[e][15]}}, ctx_q[L].a[e], 4'b0};
      end else if (d.neg) begin
        b_d[e] = (d.ovf || d.q > mi3_pkg::SatNeg) ? mi3_pkg::SatNeg : -d.q;
      end else begin
        b_d[e] = (d.ovf || d.q[31]) ? mi3_pkg::SatPos : d.q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign b00_o         = b_q[0];
  assign b01_o         = b_q[1];
  assign b02_o         = b_q[2];
  assign b10_o         = b_q[3];
  assign b11_o         = b_q[4];
  assign b12_o         = b_q[5];
  assign b20_o         = b_q[6];
  assign b21_o         = b_q[7];
  assign b22_o         = b_q[8];
  assign singular_o    = sing_q;
  assign determinant_o = det_q;

  a_sing_det : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (singular_o == (determinant_o == '0)))
    else $error("singular flag disagrees with determinant");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(v5_q))
    else $error("pipeline moved during a stall");

endmodule

// ----- bench/tb_matrix3x3_inverse.sv -----
module tb_matrix3x3_inverse;

  typedef logic signed [15:0] elem_t;
  typedef elem_t mat_t [9];

  typedef struct {
    logic signed [31:0] b [9];
    logic               sing;
    logic signed [48:0] det;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t pending_q [$];
    int       errors;
    int       matrices;
    int       singulars;
    int       checked;

    function automatic inverse_t invert(mat_t m);
      inverse_t res;
      longint   e [9];
      longint   cof [9];
      longint   d;
      longint   q;
      for (int k = 0; k < 9; k++) e[k] = m[k];
      cof[0] =   e[4] * e[8] - e[5] * e[7];
      cof[1] = -(e[3] * e[8] - e[5] * e[6]);
      cof[2] =   e[3] * e[7] - e[4] * e[6];
      cof[3] = -(e[1] * e[8] - e[2] * e[7]);
      cof[4] =   e[0] * e[8] - e[2] * e[6];
      cof[5] = -(e[0] * e[7] - e[1] * e[6]);
      cof[6] =   e[1] * e[5] - e[2] * e[4];
      cof[7] = -(e[0] * e[5] - e[2] * e[3]);
      cof[8] =   e[0] * e[4] - e[1] * e[3];
      d = e[0] * cof[0] + e[1] * cof[1] + e[2] * cof[2];
      if (d == 0) begin
        for (int k = 0; k < 9; k++) res.b[k] = 32'(e[k] * 16);
        res.sing = 1'b1;
        res.det  = '0;
      end else begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            q = (cof[c * 3 + r] * 64'sd268435456) / d;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            res.b[r * 3 + c] = 32'(q);
          end
        end
        res.sing = 1'b0;
        res.det  = 49'(d);
      end
      return res;
    endfunction

    function void note_matrix(mat_t m);
      inverse_t res;
      res = invert(m);
      matrices++;
      if (res.sing) singulars++;
      pending_q.push_back(res);
    endfunction

    function void check_result(inverse_t got);
      inverse_t exp_res;
      if (pending_q.size() == 0) begin
        $error("result word arrived with no matrix outstanding");
        errors++;
        return;
      end
      exp_res = pending_q.pop_front();
      checked++;
      for (int k = 0; k < 9; k++) begin
        if (got.b[k] !== exp_res.b[k]) begin
          $error("b%0d%0d: expected %0d, got %0d", k / 3, k % 3, exp_res.b[k], got.b[k]);
          errors++;
        end
      end
      if (got.sing !== exp_res.sing) begin
        $error("singular: expected %0d, got %0d", exp_res.sing, got.sing);
        errors++;
      end
      if (got.det !== exp_res.det) begin
        $error("determinant: expected %0d, got %0d", exp_res.det, got.det);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  elem_t       a_i [9];
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [31:0] b_o [9];
  logic        singular_o;
  logic signed [48:0] determinant_o;

  inverse_scoreboard sb;
  bit                holdoff_req;

  matrix3x3_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .a00_i(a_i[0]), .a01_i(a_i[1]), .a02_i(a_i[2]),
    .a10_i(a_i[3]), .a11_i(a_i[4]), .a12_i(a_i[5]),
    .a20_i(a_i[6]), .a21_i(a_i[7]), .a22_i(a_i[8]),
    .out_valid_o, .out_ready_i,
    .b00_o(b_o[0]), .b01_o(b_o[1]), .b02_o(b_o[2]),
    .b10_o(b_o[3]), .b11_o(b_o[4]), .b12_o(b_o[5]),
    .b20_o(b_o[6]), .b21_o(b_o[7]), .b22_o(b_o[8]),
    .singular_o, .determinant_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_matrix3x3_inverse: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    inverse_t got;
    mat_t     m;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        for (int k = 0; k < 9; k++) m[k] = a_i[k];
        sb.note_matrix(m);
      end
      if (out_valid_o && out_ready_i) begin
        for (int k = 0; k < 9; k++) got.b[k] = b_o[k];
        got.sing = singular_o;
        got.det  = determinant_o;
        sb.check_result(got);
      end
    end
  end

  // Receiver: changes its stall pattern every so often, and holds off for a
  // long stretch when the sender asks for it.
  initial begin
    int mode;
    int left;
    int phase;
    out_ready_i = 1'b0;
    mode = 0;
    left = 0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_ready_i = 1'b0;
        repeat (150) @(negedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      phase++;
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = ($urandom_range(0, 99) < 70);
        2: out_ready_i = (phase % 3 != 0);
        default: out_ready_i = ($urandom_range(0, 99) < 25);
      endcase
    end
  end

  mat_t stim_q [$];
  int   burst_left;

  task automatic send_matrix(mat_t m);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i = 1'b1;
    a_i = m;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic mat_t make_matrix(int kind);
    mat_t m;
    int   src;
    int   dst;
    for (int k = 0; k < 9; k++) m[k] = elem_t'($urandom());
    case (kind)
      0: ;
      1: for (int k = 0; k < 9; k++) m[k] = elem_t'($urandom_range(0, 15)) - 16'sd8;
      2: begin
        src = $urandom_range(0, 2);
        dst = (src + $urandom_range(1, 2)) % 3;
        for (int c = 0; c < 3; c++) m[dst * 3 + c] = m[src * 3 + c];
      end
      3: begin
        dst = $urandom_range(0, 2);
        for (int r = 0; r < 3; r++) m[r * 3 + dst] = '0;
      end
      default: begin
        for (int k = 0; k < 9; k++) begin
          if (k % 4 != 0) m[k] = elem_t'($urandom_range(0, 511)) - 16'sd256;
        end
      end
    endcase
    return m;
  endfunction

  function automatic mat_t fill(elem_t v);
    mat_t m;
    for (int k = 0; k < 9; k++) m[k] = v;
    return m;
  endfunction

  initial begin
    mat_t m;
    int   pick;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    for (int k = 0; k < 9; k++) a_i[k] = '0;
    burst_left = 0;
    holdoff_req = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    m = fill(16'sd0); m[0] = 16'sd4096; m[4] = 16'sd4096; m[8] = 16'sd4096;
    stim_q.push_back(m);
    m[4] = -16'sd4096;
    stim_q.push_back(m);
    stim_q.push_back(fill(16'sd0));
    stim_q.push_back(fill(16'sh7fff));
    stim_q.push_back(fill(16'sh8000));
    m = fill(16'sd0); m[0] = 16'sh7fff; m[4] = 16'sh7fff; m[8] = 16'sh7fff;
    stim_q.push_back(m);
    m = fill(16'sd0); m[0] = 16'sh8000; m[4] = 16'sh8000; m[8] = 16'sh8000;
    stim_q.push_back(m);
    m = fill(16'sd0); m[0] = 16'sd1; m[4] = 16'sd1; m[8] = 16'sd1;
    stim_q.push_back(m);
    m[1] = 16'sd1000;
    stim_q.push_back(m);
    m[1] = -16'sd1000;
    stim_q.push_back(m);
    m = fill(16'sd0);
    m[0] = 16'sh8000; m[1] = 16'sh7fff; m[4] = 16'sh8000; m[5] = 16'sh7fff;
    m[6] = 16'sh7fff; m[8] = 16'sh8000;
    stim_q.push_back(m);
    for (int k = 0; k < 9; k++) m[k] = (k % 2) ? 16'sh5555 : 16'shaaaa;
    stim_q.push_back(m);
    for (int k = 0; k < 9; k++) m[k] = (k % 2) ? 16'shaaaa : 16'sh5555;
    stim_q.push_back(m);
    for (int k = 0; k < 9; k++) m[k] = elem_t'(k + 1);
    stim_q.push_back(m);
    m = fill(16'sd0); m[2] = 16'sd4096; m[4] = 16'sd4096; m[6] = 16'sd4096;
    stim_q.push_back(m);
    for (int kind = 0; kind < 5; kind++) stim_q.push_back(make_matrix(kind));

    for (int n = 0; n < 700; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) stim_q.push_back(make_matrix(0));
      else if (pick < 65) stim_q.push_back(make_matrix(1));
      else if (pick < 75) stim_q.push_back(make_matrix(2));
      else if (pick < 80) stim_q.push_back(make_matrix(3));
      else stim_q.push_back(make_matrix(4));
    end

    for (int n = 0; n < stim_q.size(); n++) begin
      if (n == 300) holdoff_req = 1'b1;
      send_matrix(stim_q[n]);
    end
    in_valid_i = 1'b0;

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("Sent %0d matrices (%0d singular), checked %0d result words.",
             sb.matrices, sb.singulars, sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_matrix3x3_inverse: clean");
    end else begin
      $display("tb_matrix3x3_inverse: errors");
    end
    $finish;
  end

endmodule
